>>> rtl/skh_pkg.sv
// skh_pkg: shared types, register indexes and rotate helpers for the spaced k-mer hash stream
// used by every module of the block; depends on nothing else
`default_nettype none

package skh_pkg;

    localparam int WORD_W      = 64;
    localparam int TOP_W       = 6;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MASK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_G = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_T = 3'd4;

    // base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic [WORD_W-1:0] PATTERN_MASK_RESET = 64'd4095;

    // settings seen by the hash stage; align_mask is indexed by base age (0 = newest)
    typedef struct packed {
        logic [WORD_W-1:0]        align_mask;
        logic [TOP_W-1:0]         top;
        logic                     pattern_on;
        logic [3:0][WORD_W-1:0]   table_word;
    } skh_cfg_t;

    function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] w,
                                                    input logic [TOP_W-1:0] n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {w, w} >> n;
        return dbl[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] w,
                                                   input logic [TOP_W-1:0] n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {w, w} << n;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/skh_cfg_regs.sv
// skh_cfg_regs: configuration registers and the pattern values derived from them
// depends on skh_pkg
`default_nettype none

module skh_cfg_regs #(
    parameter int MAX_SPAN = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [skh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [skh_pkg::WORD_W-1:0]        cfg_data,
    output skh_pkg::skh_cfg_t                      cfg,
    output logic                                   settle
);
    import skh_pkg::*;

    localparam int IDX_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    logic [WORD_W-1:0]      pattern_reg;
    logic [3:0][WORD_W-1:0] table_reg;
    logic                   settle_reg;

    logic [MAX_SPAN-1:0] span_bits;
    logic [MAX_SPAN-1:0] rev_bits;
    logic [MAX_SPAN-1:0] align_next, align_reg;
    logic [IDX_W-1:0]    top_next, top_reg;
    logic                on_next, on_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PATTERN_MASK_RESET;
            table_reg   <= '0;
            settle_reg  <= 1'b1;
        end else begin
            // derived pattern values are recomputed and re-registered after any write; settle flags it
            settle_reg <= cfg_valid;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_PATTERN_MASK: pattern_reg <= cfg_data;
                    REG_TABLE_WORD_A: table_reg[BASE_A] <= cfg_data;
                    REG_TABLE_WORD_C: table_reg[BASE_C] <= cfg_data;
                    REG_TABLE_WORD_G: table_reg[BASE_G] <= cfg_data;
                    REG_TABLE_WORD_T: table_reg[BASE_T] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        span_bits = pattern_reg[MAX_SPAN-1:0];
        top_next  = '0;
        for (int i = 0; i < MAX_SPAN; i++) begin
            if (span_bits[i]) begin
                top_next = IDX_W'(i);
            end
            rev_bits[i] = span_bits[MAX_SPAN-1-i];
        end
        // pattern offset d lands on base age top-d
        align_next = rev_bits >> (IDX_W'(MAX_SPAN - 1) - top_next);
        on_next    = |span_bits;
    end

    always_ff @(posedge aclk) begin
        align_reg <= align_next;
        top_reg   <= top_next;
        on_reg    <= on_next;
    end

    always_comb begin
        cfg.align_mask = WORD_W'(align_reg);
        cfg.top        = TOP_W'(top_reg);
        cfg.pattern_on = on_reg;
        cfg.table_word = table_reg;
    end

    assign settle = settle_reg;

endmodule

`default_nettype wire

>>> rtl/skh_history.sv
// skh_history: input register stage holding the base history window and fill count
// depends on skh_pkg
`default_nettype none

module skh_history #(
    parameter int MAX_SPAN = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_take,
    input  wire logic [1:0]                              base_code,
    input  wire logic                                    base_unknown,
    input  wire logic                                    seq_last,
    input  wire logic                                    out_take,
    output logic [MAX_SPAN-1:0][2:0]                     hist,
    output logic [$clog2(MAX_SPAN+1)-1:0]                fill,
    output logic                                         item_last,
    output logic                                         item_valid
);
    import skh_pkg::*;

    localparam int FILL_W = $clog2(MAX_SPAN + 1);

    logic [MAX_SPAN-1:0][2:0] hist_reg, hist_next, base_hist;
    logic [FILL_W-1:0]        fill_reg, fill_next, base_fill;
    logic                     last_reg;
    logic                     valid_reg;
    logic                     clear_pending_reg;

    always_comb begin
        // a finished sequence starts over from an empty history
        base_hist = clear_pending_reg ? '0 : hist_reg;
        base_fill = clear_pending_reg ? '0 : fill_reg;
        hist_next = {base_hist[MAX_SPAN-2:0], base_unknown, base_code};
        fill_next = (base_fill == FILL_W'(MAX_SPAN)) ? base_fill : base_fill + FILL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg         <= 1'b0;
            clear_pending_reg <= 1'b1;
        end else if (in_take) begin
            valid_reg         <= 1'b1;
            clear_pending_reg <= seq_last;
        end else if (out_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            hist_reg <= hist_next;
            fill_reg <= fill_next;
            last_reg <= seq_last;
        end
    end

    assign hist       = hist_reg;
    assign fill       = fill_reg;
    assign item_last  = last_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/skh_hash_stage.sv
// skh_hash_stage: window hash and fault check, faulty window counter and result register
// depends on skh_pkg
`default_nettype none

module skh_hash_stage #(
    parameter int MAX_SPAN = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire skh_pkg::skh_cfg_t                cfg,
    input  wire logic [MAX_SPAN-1:0][2:0]         hist,
    input  wire logic [$clog2(MAX_SPAN+1)-1:0]    fill,
    input  wire logic                             item_last,
    input  wire logic                             item_valid,
    output logic                                  item_take,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [skh_pkg::WORD_W-1:0]            hash_value,
    output logic                                  hash_valid,
    output logic                                  window_faulty,
    output logic [31:0]                           faulty_count,
    output logic                                  seq_done
);
    import skh_pkg::*;

    localparam int FILL_W = $clog2(MAX_SPAN + 1);

    logic [WORD_W-1:0] xor_acc;
    logic              bad;
    logic              closes;
    logic              hv_next, wf_next;
    logic [WORD_W-1:0] hash_next;
    logic [31:0]       count_next;

    logic              out_valid_reg;
    logic [31:0]       total_reg;
    logic [WORD_W-1:0] hash_reg;
    logic              hv_reg, wf_reg, done_reg;
    logic [31:0]       count_reg;

    always_comb begin
        logic [2:0] sym;
        xor_acc = '0;
        bad     = 1'b0;
        sym     = '0;
        // each term is pre-rotated right by its age; one left rotate by top finishes it
        for (int j = 0; j < MAX_SPAN; j++) begin
            sym = hist[j];
            if (cfg.align_mask[j]) begin
                bad     = bad | sym[2];
                xor_acc = xor_acc ^ rot_right(cfg.table_word[sym[1:0]], TOP_W'(j));
            end
        end
        closes     = cfg.pattern_on && (fill > FILL_W'(cfg.top));
        hv_next    = closes && !bad;
        wf_next    = closes && bad;
        hash_next  = hv_next ? rot_left(xor_acc, cfg.top) : '0;
        count_next = (wf_next && (total_reg != '1)) ? total_reg + 32'd1 : total_reg;
    end

    assign item_take = item_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else if (item_take) begin
            out_valid_reg <= 1'b1;
            total_reg     <= item_last ? '0 : count_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            hash_reg  <= hash_next;
            hv_reg    <= hv_next;
            wf_reg    <= wf_next;
            count_reg <= count_next;
            done_reg  <= item_last;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign hash_value    = hash_reg;
    assign hash_valid    = hv_reg;
    assign window_faulty = wf_reg;
    assign faulty_count  = count_reg;
    assign seq_done      = done_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(hv_reg && wf_reg))
        else $error("hash_valid and window_faulty both set");

    a_hash_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !hv_reg) |-> (hash_reg == '0))
        else $error("hash_value nonzero without hash_valid");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && !item_last && (total_reg == '1)) |=> (total_reg == '1))
        else $error("faulty counter wrapped");

    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item_last) |=> (total_reg == '0))
        else $error("faulty counter not cleared at sequence end");
`endif

endmodule

`default_nettype wire

>>> rtl/spaced_kmer_hash_stream_unit.sv
// spaced_kmer_hash_stream_unit: top level of the spaced k-mer rolling hash over a base stream
// depends on skh_pkg, skh_cfg_regs, skh_history, skh_hash_stage
`default_nettype none

// One base enters per transfer and one result leaves per base. A taken base is written into
// the history register and its result is then registered in the result register, so a new
// base can be accepted every cycle while m_tready does not hold back the result register.
// The history register holds the last MAX_SPAN bases; the window hash is an XOR over the
// pattern offsets of fixed-rotated table words followed by one rotate by the highest
// pattern offset, all between the history register and the result register. After reset
// and after every configuration write the input side holds s_tready low while the pattern
// span and offset alignment are recomputed; configuration transfers are always accepted.
module spaced_kmer_hash_stream_unit #(
    parameter int MAX_SPAN = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // base input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [1:0] base_code, rest zero
    input  wire logic [0:0]                        s_tuser,   // [0] base_unknown
    input  wire logic                              s_tlast,   // seq_last
    // hash result
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [95:0]                            m_tdata,   // [63:0] hash_value, [95:64] faulty_count
    output logic [1:0]                             m_tuser,   // [0] hash_valid, [1] window_faulty
    output logic                                   m_tlast,   // seq_done
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [skh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [skh_pkg::WORD_W-1:0]        cfg_data
);
    import skh_pkg::*;

    localparam int FILL_W = $clog2(MAX_SPAN + 1);

    skh_cfg_t                 cfg;
    logic                     settle;
    logic                     in_take;
    logic                     item_take;
    logic                     item_valid;
    logic                     item_last;
    logic [MAX_SPAN-1:0][2:0] hist;
    logic [FILL_W-1:0]        fill;
    logic [WORD_W-1:0]        hash_value;
    logic                     hash_valid;
    logic                     window_faulty;
    logic [31:0]              faulty_count;
    logic                     seq_done;

    assign s_tready = !settle && (!item_valid || item_take);
    assign in_take  = s_tvalid && s_tready;

    skh_cfg_regs #(
        .MAX_SPAN (MAX_SPAN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .settle    (settle)
    );

    skh_history #(
        .MAX_SPAN (MAX_SPAN)
    ) u_history (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_take      (in_take),
        .base_code    (s_tdata[1:0]),
        .base_unknown (s_tuser[0]),
        .seq_last     (s_tlast),
        .out_take     (item_take),
        .hist         (hist),
        .fill         (fill),
        .item_last    (item_last),
        .item_valid   (item_valid)
    );

    skh_hash_stage #(
        .MAX_SPAN (MAX_SPAN)
    ) u_hash (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .hist          (hist),
        .fill          (fill),
        .item_last     (item_last),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .hash_value    (hash_value),
        .hash_valid    (hash_valid),
        .window_faulty (window_faulty),
        .faulty_count  (faulty_count),
        .seq_done      (seq_done)
    );

    assign m_tdata = {faulty_count, hash_value};
    assign m_tuser = {window_faulty, hash_valid};
    assign m_tlast = seq_done;

endmodule

`default_nettype wire
